### rtl/slr_pkg.sv
// Package with the shared types and constants of the servo slew-rate limiter.
`default_nettype none

package slr_pkg;

    // Field widths.
    localparam int unsigned ANGLE_W = 8;
    localparam int unsigned PULSE_W = 12;
    localparam int unsigned SPEED_W = 10;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned STEP_W  = 5;
    localparam int unsigned SLICE_W = 11;
    localparam int unsigned INC_W   = STEP_W + SLICE_W;

    // Angle and pulse constants.
    localparam logic [ANGLE_W-1:0] ANGLE_MAX   = 8'd180;
    localparam logic [PULSE_W-1:0] PULSE_MIN   = 12'd600;
    localparam logic [PULSE_W-1:0] PULSE_MAX   = 12'd2400;
    localparam logic [PULSE_W-1:0] PULSE_RESET = 12'd1500;

    // Register reset values.
    localparam logic [ANGLE_W-1:0] LOW_RESET   = 8'd0;
    localparam logic [ANGLE_W-1:0] HIGH_RESET  = 8'd180;
    localparam logic [SPEED_W-1:0] SPEED_JUMP  = 10'd1000;
    localparam logic [SPEED_W-1:0] SPEED_RESET = 10'd1000;
    localparam logic [STEP_W-1:0]  STEP_RESET  = 5'd25;

    // Step per slice is speed / 40, done as (speed * 1639) >> 16, exact for 10-bit speed.
    localparam logic [10:0]  STEP_RECIP = 11'd1639;
    localparam int unsigned  STEP_SH    = 16;

    // Command codes.
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_OFF   = 2'd1,
        OP_ON    = 2'd2
    } t_opcode;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_LOW   = 2'd0,
        REG_HIGH  = 2'd1,
        REG_SPEED = 2'd2
    } t_reg_idx;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [ANGLE_W-1:0] low;
        logic [ANGLE_W-1:0] high;
        logic               jump;
        logic [STEP_W-1:0]  step;
    } t_cfg;

    // Word held between the time-base stage and the slew stage.
    typedef struct packed {
        logic               valid;
        logic               jump;
        logic [PULSE_W-1:0] target;
        logic [SLICE_W-1:0] slices;
    } t_s1;

endpackage

`default_nettype wire

### rtl/slr_if.sv
// Channel interfaces for the command words and the result words.
`default_nettype none

interface slr_cmd_if import slr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [ANGLE_W-1:0] angle;
    logic [TIME_W-1:0]  now_ms;

    modport source (output valid, output opcode, output angle, output now_ms, input ready);
    modport sink   (input valid, input opcode, input angle, input now_ms, output ready);
endinterface

interface slr_res_if import slr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PULSE_W-1:0] pulse_us;
    logic               at_target;

    modport source (output valid, output pulse_us, output at_target, input ready);
    modport sink   (input valid, input pulse_us, input at_target, output ready);
endinterface

`default_nettype wire

### rtl/servo_slew_rate_limiter_core.sv
// Top level of the servo pulse slew-rate limiter.
//
//  Channel   Direction  Words              Handshake
//  i_cmd     in         opcode/angle/time  valid/ready
//  o_res     out        pulse_us/at_target valid/ready
//  APB       in/out     limits and speed   psel/penable, pready always high
//
// One command word is taken every cycle unless the output stalls; a command that issues a move
// passes the command stage register and then the output register, which hold one word each.
// Reset is synchronous; there is no clearing pass.
// A stalled output holds its word while the command stage still takes one more word.
`default_nettype none

module servo_slew_rate_limiter_core import slr_pkg::*; #(
    parameter int unsigned SLICE_MS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    slr_cmd_if.sink     i_cmd,
    slr_res_if.source   o_res
);

    t_cfg w_cfg;
    t_s1  w_s1;
    logic w_adv;

    // Configuration registers.
    slr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Command stage.
    slr_track #(
        .SLICE_MS (SLICE_MS)
    ) u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_cmd   (i_cmd),
        .i_adv   (w_adv),
        .o_s1    (w_s1)
    );

    // Slew stage and output register.
    slr_slew u_slew (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_s1    (w_s1),
        .o_adv   (w_adv),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

### rtl/slr_cfg.sv
// Configuration registers behind the APB-style port.
`default_nettype none

module slr_cfg import slr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [ANGLE_W-1:0] r_low;
    logic [ANGLE_W-1:0] r_high;
    logic [SPEED_W-1:0] r_speed;
    logic [STEP_W-1:0]  r_step;
    logic               w_wr;
    logic [20:0]        w_step_prod;
    logic [STEP_W-1:0]  n_step;
    t_reg_idx           w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[3:2]);

    // The step per slice is derived once, when the speed is written.
    assign w_step_prod = 21'(pwdata[SPEED_W-1:0]) * 21'(STEP_RECIP);
    assign n_step      = w_step_prod[STEP_SH +: STEP_W];

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low   <= LOW_RESET;
            r_high  <= HIGH_RESET;
            r_speed <= SPEED_RESET;
            r_step  <= STEP_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_LOW:   r_low <= pwdata[ANGLE_W-1:0];
                REG_HIGH:  r_high <= pwdata[ANGLE_W-1:0];
                REG_SPEED: begin
                    r_speed <= pwdata[SPEED_W-1:0];
                    r_step  <= n_step;
                end
                default: ;
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        unique case (w_idx)
            REG_LOW:   prdata = 32'(r_low);
            REG_HIGH:  prdata = 32'(r_high);
            REG_SPEED: prdata = 32'(r_speed);
            default:   prdata = 32'd0;
        endcase
    end

    assign o_cfg.low  = r_low;
    assign o_cfg.high = r_high;
    assign o_cfg.jump = (r_speed == SPEED_JUMP);
    assign o_cfg.step = r_step;

endmodule

`default_nettype wire

### rtl/slr_track.sv
// Command stage: target mapping, time base and slice count.
`default_nettype none

module slr_track import slr_pkg::*; #(
    parameter int unsigned SLICE_MS = 10
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    slr_cmd_if.sink  i_cmd,
    input  logic     i_adv,
    output t_s1      o_s1
);

    // Division of a 16-bit value by SLICE_MS as a multiply by a rounded-up reciprocal.
    localparam int unsigned     RECIP_SH   = 16 + $clog2(SLICE_MS);
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << RECIP_SH) + 64'(SLICE_MS) - 64'd1) / 64'(SLICE_MS);
    localparam logic [17:0]     RECIP_M    = RECIP_FULL[17:0];
    localparam int unsigned     PROD_W     = RECIP_SH + 17;

    logic               r_enabled;
    logic               r_was_dis;
    logic [TIME_W-1:0]  r_last;
    t_s1                r_s1;

    logic               n_enabled;
    logic               n_was_dis;
    logic [TIME_W-1:0]  n_last;
    logic               w_issue;
    logic               w_fire;
    logic [ANGLE_W-1:0] w_a1;
    logic [ANGLE_W-1:0] w_a2;
    logic [ANGLE_W-1:0] w_a3;
    logic [PULSE_W-1:0] w_target;
    logic [TIME_W-1:0]  w_base;
    logic [TIME_W-1:0]  w_elapsed;
    logic               w_late;
    logic [PROD_W-1:0]  w_prod;
    logic [15:0]        w_quot;
    logic [SLICE_W-1:0] w_slices;

    assign i_cmd.ready = !r_s1.valid || i_adv;
    assign w_fire      = i_cmd.valid && i_cmd.ready;

    // Clamp: low limit first, then high limit, then the mechanical maximum.
    assign w_a1     = (i_cmd.angle < i_cfg.low) ? i_cfg.low : i_cmd.angle;
    assign w_a2     = (w_a1 > i_cfg.high) ? i_cfg.high : w_a1;
    assign w_a3     = (w_a2 > ANGLE_MAX) ? ANGLE_MAX : w_a2;
    assign w_target = (PULSE_W'(w_a3) << 3) + (PULSE_W'(w_a3) << 1) + PULSE_MIN;

    // The time base restarts when the servo was off or has just come back.
    assign w_base    = (r_was_dis || !r_enabled) ? i_cmd.now_ms : r_last;
    assign w_elapsed = i_cmd.now_ms - w_base;
    assign w_late    = (w_elapsed >= TIME_W'(SLICE_MS));

    // Slice count from the low 16 bits of the elapsed time, saturated.
    assign w_prod   = PROD_W'(w_elapsed[15:0]) * PROD_W'(RECIP_M);
    assign w_quot   = w_prod[RECIP_SH +: 16];
    assign w_slices = (|w_quot[15:SLICE_W]) ? {SLICE_W{1'b1}} : w_quot[SLICE_W-1:0];

    // Next state of the time base and the enable flags.
    always_comb begin
        n_enabled = r_enabled;
        n_was_dis = r_was_dis;
        n_last    = r_last;
        w_issue   = 1'b0;
        unique case (t_opcode'(i_cmd.opcode))
            OP_OFF: begin
                n_enabled = 1'b0;
                n_was_dis = 1'b1;
            end
            OP_ON: begin
                n_enabled = 1'b1;
            end
            OP_WRITE: begin
                if (i_cfg.jump) begin
                    w_issue = 1'b1;
                end else begin
                    n_was_dis = 1'b0;
                    if (w_late) begin
                        w_issue = 1'b1;
                        n_last  = i_cmd.now_ms;
                    end else begin
                        n_last  = w_base;
                    end
                end
            end
            default: ;
        endcase
    end

    // Control state, the stage valid flag and the stage payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled  <= 1'b1;
            r_was_dis  <= 1'b1;
            r_last     <= '0;
            r_s1.valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_enabled <= n_enabled;
                r_was_dis <= n_was_dis;
                r_last    <= n_last;
            end
            if (w_fire && w_issue) begin
                r_s1.valid  <= 1'b1;
                r_s1.jump   <= i_cfg.jump;
                r_s1.target <= w_target;
                r_s1.slices <= w_slices;
            end else if (i_adv) begin
                r_s1.valid <= 1'b0;
            end
        end
    end

    assign o_s1 = r_s1;

`ifndef SYNTHESIS
    // A deactivate always leaves the servo off with the time base pending restart.
    a_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_cmd.opcode == OP_OFF) |=> (!r_enabled && r_was_dis))
        else $error("deactivate did not take effect");
`endif

endmodule

`default_nettype wire

### rtl/slr_slew.sv
// Slew stage: moves the held pulse toward the target and holds the result word.
`default_nettype none

module slr_slew import slr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_s1       i_s1,
    output logic      o_adv,
    slr_res_if.source o_res
);

    logic [PULSE_W-1:0] r_cur_pulse;
    logic               r_out_valid;
    logic [PULSE_W-1:0] r_out_pulse;
    logic               r_out_at_target;

    logic               w_xfer;
    logic [INC_W-1:0]   w_inc;
    logic               w_up;
    logic [PULSE_W-1:0] w_diff;
    logic [PULSE_W-1:0] w_move;
    logic [PULSE_W-1:0] n_pulse;

    assign o_adv  = !r_out_valid || o_res.ready;
    assign w_xfer = i_s1.valid && o_adv;

    // Largest move allowed for the elapsed slices.
    assign w_inc  = INC_W'(i_cfg.step) * INC_W'(i_s1.slices);

    // Distance to the target and the clipped move.
    assign w_up   = (i_s1.target > r_cur_pulse);
    assign w_diff = w_up ? (i_s1.target - r_cur_pulse) : (r_cur_pulse - i_s1.target);
    assign w_move = (INC_W'(w_diff) > w_inc) ? w_inc[PULSE_W-1:0] : w_diff;

    always_comb begin
        if (i_s1.jump) begin
            n_pulse = i_s1.target;
        end else if (w_up) begin
            n_pulse = r_cur_pulse + w_move;
        end else begin
            n_pulse = r_cur_pulse - w_move;
        end
    end

    // Held pulse and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_pulse <= PULSE_RESET;
            r_out_valid <= 1'b0;
        end else if (w_xfer) begin
            r_cur_pulse <= n_pulse;
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result word payload.
    always_ff @(posedge i_clk) begin
        if (w_xfer) begin
            r_out_pulse     <= n_pulse;
            r_out_at_target <= (n_pulse == i_s1.target);
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.pulse_us  = r_out_pulse;
    assign o_res.at_target = r_out_at_target;

`ifndef SYNTHESIS
    // The held pulse never leaves the mechanical range.
    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_pulse >= PULSE_MIN && r_cur_pulse <= PULSE_MAX))
        else $error("held pulse out of range");

    // A pending result always shows the pulse now held.
    a_out_cur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_pulse == r_cur_pulse))
        else $error("result word differs from held pulse");

    // An immediate move always lands on the target.
    a_jump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_xfer && i_s1.jump) |=> (r_out_valid && r_out_at_target))
        else $error("immediate move missed the target");
`endif

endmodule

`default_nettype wire
